/* rtl/sm4bc_pkg.sv */
// Shared types, constant tables and helper functions for the SM4 block cipher.
package sm4bc_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_KEY_HIGH   = 3'd0,
        REG_KEY_LOW    = 3'd1,
        REG_IV_HIGH    = 3'd2,
        REG_IV_LOW     = 3'd3,
        REG_CHAIN_MODE = 3'd4,
        REG_DECRYPT    = 3'd5
    } cfg_reg_t;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_KEXP   = 5'b00010,
        ST_LOAD   = 5'b00100,
        ST_RUN    = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    localparam logic [31:0] FK [4] = '{
        32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
    };

    localparam logic [31:0] CK [32] = '{
        32'h00070e15, 32'h1c232a31, 32'h383f464d, 32'h545b6269,
        32'h70777e85, 32'h8c939aa1, 32'ha8afb6bd, 32'hc4cbd2d9,
        32'he0e7eef5, 32'hfc030a11, 32'h181f262d, 32'h343b4249,
        32'h50575e65, 32'h6c737a81, 32'h888f969d, 32'ha4abb2b9,
        32'hc0c7ced5, 32'hdce3eaf1, 32'hf8ff060d, 32'h141b2229,
        32'h30373e45, 32'h4c535a61, 32'h686f767d, 32'h848b9299,
        32'ha0a7aeb5, 32'hbcc3cad1, 32'hd8dfe6ed, 32'hf4fb0209,
        32'h10171e25, 32'h2c333a41, 32'h484f565d, 32'h646b7279
    };

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // Byte-wise S-box substitution of a 32-bit word.
    function automatic logic [31:0] tau(input logic [31:0] x);
        tau = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // Linear transform used by the data rounds.
    function automatic logic [31:0] lin_data(input logic [31:0] b);
        lin_data = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    // Linear transform used by the key schedule.
    function automatic logic [31:0] lin_key(input logic [31:0] b);
        lin_key = b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

endpackage

/* rtl/sm4bc_round_unit.sv */
// Shared SM4 round function, used by both the key schedule and the data rounds.
module sm4bc_round_unit
(
    input  logic [31:0] x0,
    input  logic [31:0] x1,
    input  logic [31:0] x2,
    input  logic [31:0] x3,
    input  logic [31:0] rk,
    input  logic        key_mode,
    output logic [31:0] nx
);

    logic [31:0] mix;
    logic [31:0] sub;

    always_comb
    begin
        mix = x1 ^ x2 ^ x3 ^ rk;
        sub = sm4bc_pkg::tau(mix);
        if (key_mode)
        begin
            nx = x0 ^ sm4bc_pkg::lin_key(sub);
        end
        else
        begin
            nx = x0 ^ sm4bc_pkg::lin_data(sub);
        end
    end

endmodule

/* rtl/sm4bc_key_mem.sv */
// Round key memory: one write port and one registered read port.
module sm4bc_key_mem
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/sm4_block_cipher_ecb_cbc.sv */
// Top level of the SM4 block cipher with ECB and CBC chaining.
//
// SM4 block cipher, 128-bit block and 128-bit key, in ECB or CBC mode, encrypt or
// decrypt. A block enters as two big-endian 64-bit halves on the input channel and
// leaves as two halves on the output channel; every input beat yields exactly one
// output beat. One round function is shared by the key schedule and the data path
// and is used once per clock. A block goes through an accept step, 32 rounds and
// a step that hands the result to the output register; the next input beat is
// taken after that hand-off. The output register holds a finished block while
// the next one is already being accepted and processed. After the key registers are
// written, the first block also runs the key schedule through the same round unit,
// which adds 32 expansion rounds and then a step that reloads the block.
// Round keys live in a 32-entry memory with a registered read; decryption reads them
// in reverse order. In CBC mode a block flagged first_block reloads the chaining
// value from the IV registers; after that the chaining value follows the ciphertext.
// In ECB mode the chaining value is only touched by first_block. Configuration writes
// are taken at any time on the write channel (cfg_ready is always high) but must only
// be issued while no block is in flight. Writes to undefined indexes are ignored.
module sm4_block_cipher_ecb_cbc
#(
    parameter int ROUNDS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_high,
    input  logic [63:0] data_low,
    input  logic        first_block,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] out_high,
    output logic [63:0] out_low
);

    localparam int CntW = $clog2(ROUNDS);
    localparam logic [CntW-1:0] LastIdx = CntW'(ROUNDS - 1);

    // Configuration registers.
    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [63:0] iv_high_reg;
    logic [63:0] iv_low_reg;
    logic        chain_mode_reg;
    logic        decrypt_reg;

    // Control state.
    sm4bc_pkg::state_t state_reg, state_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic              keys_ready_reg;
    logic              out_valid_reg;

    // Datapath state.
    logic [31:0] x0_reg, x1_reg, x2_reg, x3_reg;
    logic [63:0] hold_high_reg, hold_low_reg;
    logic [63:0] chain_high_reg, chain_low_reg;
    logic [63:0] out_high_reg, out_low_reg;

    // Round unit and key memory hookup.
    logic [31:0]     rk_mem;
    logic [31:0]     round_rk;
    logic [31:0]     round_nx;
    logic            key_mode;
    logic            kmem_wr_en;
    logic [CntW-1:0] kmem_rd_addr;
    logic [CntW-1:0] start_idx;
    logic [CntW-1:0] cnt_inc;

    logic            in_accept;
    logic            cfg_write;
    logic            cbc_enc;
    logic            cbc_dec;
    logic            out_free;
    logic            finish_load;
    logic [63:0]     cv_high_eff, cv_low_eff;
    logic [63:0]     blk_high, blk_low;
    logic [63:0]     res_high, res_low;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_stall  = (state_reg != sm4bc_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cbc_enc   = chain_mode_reg && !decrypt_reg;
    assign cbc_dec   = chain_mode_reg && decrypt_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign finish_load = (state_reg == sm4bc_pkg::ST_FINISH) && out_free;

    assign key_mode  = (state_reg == sm4bc_pkg::ST_KEXP);
    assign round_rk  = key_mode ? sm4bc_pkg::CK[cnt_reg] : rk_mem;
    assign kmem_wr_en = key_mode;
    assign cnt_inc   = CntW'(cnt_reg + 1'b1);
    assign start_idx = decrypt_reg ? LastIdx : '0;

    // The read for round i+1 is issued during round i; the first read is issued on the
    // accept edge or in the reload cycle after key expansion.
    always_comb
    begin
        if (state_reg == sm4bc_pkg::ST_RUN)
        begin
            kmem_rd_addr = decrypt_reg ? (LastIdx - cnt_inc) : cnt_inc;
        end
        else
        begin
            kmem_rd_addr = start_idx;
        end
    end

    sm4bc_round_unit u_round
    (
        .x0       (x0_reg),
        .x1       (x1_reg),
        .x2       (x2_reg),
        .x3       (x3_reg),
        .rk       (round_rk),
        .key_mode (key_mode),
        .nx       (round_nx)
    );

    sm4bc_key_mem
    #(
        .DEPTH (ROUNDS),
        .AW    (CntW)
    )
    u_key_mem
    (
        .clk     (clk),
        .wr_en   (kmem_wr_en),
        .wr_addr (cnt_reg),
        .wr_data (round_nx),
        .rd_addr (kmem_rd_addr),
        .rd_data (rk_mem)
    );

    // Chaining value as seen by a block being accepted now.
    assign cv_high_eff = first_block ? iv_high_reg : chain_high_reg;
    assign cv_low_eff  = first_block ? iv_low_reg  : chain_low_reg;

    // Block entering the rounds: on the accept edge from the ports, after key expansion
    // from the held copy (the chaining value has been reloaded by then).
    always_comb
    begin
        if (state_reg == sm4bc_pkg::ST_IDLE)
        begin
            blk_high = data_high ^ (cbc_enc ? cv_high_eff : 64'd0);
            blk_low  = data_low  ^ (cbc_enc ? cv_low_eff  : 64'd0);
        end
        else
        begin
            blk_high = hold_high_reg ^ (cbc_enc ? chain_high_reg : 64'd0);
            blk_low  = hold_low_reg  ^ (cbc_enc ? chain_low_reg  : 64'd0);
        end
    end

    // Final word order is reversed; CBC decryption folds in the chaining value.
    always_comb
    begin
        res_high = {x3_reg, x2_reg} ^ (cbc_dec ? chain_high_reg : 64'd0);
        res_low  = {x1_reg, x0_reg} ^ (cbc_dec ? chain_low_reg  : 64'd0);
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            sm4bc_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (in_accept)
                begin
                    state_next = keys_ready_reg ? sm4bc_pkg::ST_RUN : sm4bc_pkg::ST_KEXP;
                end
            end
            sm4bc_pkg::ST_KEXP:
            begin
                cnt_next = cnt_inc;
                if (cnt_reg == LastIdx)
                begin
                    state_next = sm4bc_pkg::ST_LOAD;
                end
            end
            sm4bc_pkg::ST_LOAD:
            begin
                cnt_next   = '0;
                state_next = sm4bc_pkg::ST_RUN;
            end
            sm4bc_pkg::ST_RUN:
            begin
                cnt_next = cnt_inc;
                if (cnt_reg == LastIdx)
                begin
                    state_next = sm4bc_pkg::ST_FINISH;
                end
            end
            sm4bc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = sm4bc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sm4bc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sm4bc_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Configuration registers and the key-valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg   <= '0;
            key_low_reg    <= '0;
            iv_high_reg    <= '0;
            iv_low_reg     <= '0;
            chain_mode_reg <= 1'b0;
            decrypt_reg    <= 1'b0;
            keys_ready_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == sm4bc_pkg::ST_KEXP) && (cnt_reg == LastIdx))
            begin
                keys_ready_reg <= 1'b1;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    sm4bc_pkg::REG_KEY_HIGH:
                    begin
                        key_high_reg   <= cfg_data;
                        keys_ready_reg <= 1'b0;
                    end
                    sm4bc_pkg::REG_KEY_LOW:
                    begin
                        key_low_reg    <= cfg_data;
                        keys_ready_reg <= 1'b0;
                    end
                    sm4bc_pkg::REG_IV_HIGH:    iv_high_reg    <= cfg_data;
                    sm4bc_pkg::REG_IV_LOW:     iv_low_reg     <= cfg_data;
                    sm4bc_pkg::REG_CHAIN_MODE: chain_mode_reg <= cfg_data[0];
                    sm4bc_pkg::REG_DECRYPT:    decrypt_reg    <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Chaining value: reloaded on a first block, updated when a CBC result is handed off.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_high_reg <= '0;
            chain_low_reg  <= '0;
        end
        else if (in_accept && first_block)
        begin
            chain_high_reg <= iv_high_reg;
            chain_low_reg  <= iv_low_reg;
        end
        else if (finish_load && cbc_enc)
        begin
            chain_high_reg <= res_high;
            chain_low_reg  <= res_low;
        end
        else if (finish_load && cbc_dec)
        begin
            chain_high_reg <= hold_high_reg;
            chain_low_reg  <= hold_low_reg;
        end
    end

    // Working words, shared by the key schedule and the data rounds.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hold_high_reg <= data_high;
            hold_low_reg  <= data_low;
        end

        if (in_accept && !keys_ready_reg)
        begin
            x0_reg <= key_high_reg[63:32] ^ sm4bc_pkg::FK[0];
            x1_reg <= key_high_reg[31:0]  ^ sm4bc_pkg::FK[1];
            x2_reg <= key_low_reg[63:32]  ^ sm4bc_pkg::FK[2];
            x3_reg <= key_low_reg[31:0]   ^ sm4bc_pkg::FK[3];
        end
        else if (in_accept || (state_reg == sm4bc_pkg::ST_LOAD))
        begin
            x0_reg <= blk_high[63:32];
            x1_reg <= blk_high[31:0];
            x2_reg <= blk_low[63:32];
            x3_reg <= blk_low[31:0];
        end
        else if ((state_reg == sm4bc_pkg::ST_KEXP) || (state_reg == sm4bc_pkg::ST_RUN))
        begin
            x0_reg <= x1_reg;
            x1_reg <= x2_reg;
            x2_reg <= x3_reg;
            x3_reg <= round_nx;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_load)
        begin
            out_high_reg <= res_high;
            out_low_reg  <= res_low;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_high  = out_high_reg;
    assign out_low   = out_low_reg;

`ifndef SYNTHESIS
    // The data rounds never run on a key schedule that has not been completed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sm4bc_pkg::ST_RUN) |-> keys_ready_reg)
        else $error("data rounds started without expanded round keys");

    // The last expansion round marks the keys as ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == sm4bc_pkg::ST_KEXP) && (cnt_reg == LastIdx) && !cfg_write)
        |=> keys_ready_reg)
        else $error("key expansion finished without setting keys ready");

    // After the last data round the block goes to the output handoff.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == sm4bc_pkg::ST_RUN) && (cnt_reg == LastIdx))
        |=> (state_reg == sm4bc_pkg::ST_FINISH))
        else $error("round counter did not end the data rounds");

    // A new output beat only appears from the handoff cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == sm4bc_pkg::ST_FINISH))
        else $error("output became valid outside the handoff cycle");
`endif

endmodule

/* bench/tb.sv */
// Self-checking testbench for the SM4 ECB/CBC block cipher.
module tb;

    // Register indexes past the end of the map; writes to them must be dropped.
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    // Cycles with no beat on any channel before the run is declared hung.
    localparam int STALL_LIMIT = 5000;
    // Length of the long output hold-off used to back the block up.
    localparam int HOLD_OFF_CYCLES = 300;
    // Extra cycles allowed after the last result before the verdict.
    localparam int DRAIN_CYCLES = 80;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    localparam logic [7:0] SM4_SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } block_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        first_block;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] out_high;
    logic [63:0] out_low;

    sm4_block_cipher_ecb_cbc DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_high  (data_high),
        .data_low   (data_low),
        .first_block(first_block),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_high   (out_high),
        .out_low    (out_low)
    );

    // Mirror of the block's configuration and cipher state, updated as beats are accepted.
    logic [63:0]  mdl_key_hi;
    logic [63:0]  mdl_key_lo;
    logic [63:0]  mdl_iv_hi;
    logic [63:0]  mdl_iv_lo;
    logic         mdl_cbc;
    logic         mdl_dec;
    logic [31:0]  mdl_rk [32];
    logic         mdl_rk_valid;
    logic [127:0] mdl_chain;

    // Cipher output blocks still owed by the block, oldest first.
    block_t cipher_out_q[$];
    block_t check_want;

    int  error_count;
    int  sent_count;
    int  checked_count;
    int  cfg_count;
    int  quiet_cycles;
    int  sender_idle_pct;
    int  sink_stall_pct;
    logic hold_off;

    // ------------------------------------------------------------------
    // Cipher arithmetic, written out independently of the design.
    // ------------------------------------------------------------------

    function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
        logic [63:0] twice;
        twice = {x, x} >> (32 - n);
        return twice[31:0];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] x);
        logic [31:0] r;
        for (int b = 0; b < 4; b++)
        begin
            r[8*b +: 8] = SM4_SBOX[x[8*b +: 8]];
        end
        return r;
    endfunction

    function automatic logic [31:0] data_mix(input logic [31:0] b);
        return b ^ rot_left(b, 2) ^ rot_left(b, 10) ^ rot_left(b, 18) ^ rot_left(b, 24);
    endfunction

    function automatic logic [31:0] key_mix(input logic [31:0] b);
        return b ^ rot_left(b, 13) ^ rot_left(b, 23);
    endfunction

    // The CK constants follow a simple rule: byte j of word i is (4*i + j) * 7 mod 256.
    function automatic logic [31:0] ck_word(input int i);
        logic [31:0] r;
        logic [7:0]  v;
        for (int j = 0; j < 4; j++)
        begin
            v = 8'((4 * i + j) * 7);
            r[31 - 8*j -: 8] = v;
        end
        return r;
    endfunction

    function automatic void expand_round_keys();
        logic [31:0] w [4];
        logic [31:0] nk;
        w[0] = mdl_key_hi[63:32] ^ FK0;
        w[1] = mdl_key_hi[31:0]  ^ FK1;
        w[2] = mdl_key_lo[63:32] ^ FK2;
        w[3] = mdl_key_lo[31:0]  ^ FK3;
        for (int i = 0; i < 32; i++)
        begin
            nk = w[0] ^ key_mix(sub_word(w[1] ^ w[2] ^ w[3] ^ ck_word(i)));
            w[0] = w[1];
            w[1] = w[2];
            w[2] = w[3];
            w[3] = nk;
            mdl_rk[i] = nk;
        end
        mdl_rk_valid = 1'b1;
    endfunction

    function automatic logic [127:0] run_rounds(input logic [127:0] blk, input logic reverse);
        logic [31:0] x [4];
        logic [31:0] rk;
        logic [31:0] nx;
        x[0] = blk[127:96];
        x[1] = blk[95:64];
        x[2] = blk[63:32];
        x[3] = blk[31:0];
        for (int i = 0; i < 32; i++)
        begin
            rk = reverse ? mdl_rk[31 - i] : mdl_rk[i];
            nx = x[0] ^ data_mix(sub_word(x[1] ^ x[2] ^ x[3] ^ rk));
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = nx;
        end
        return {x[3], x[2], x[1], x[0]};
    endfunction

    // Works out the result block for one accepted input beat and advances the chain.
    function automatic block_t sm4_process_block(input logic [63:0] hi, input logic [63:0] lo,
                                                 input logic fb);
        logic [127:0] din;
        logic [127:0] res;
        din = {hi, lo};
        if (!mdl_rk_valid)
            expand_round_keys();
        if (fb)
            mdl_chain = {mdl_iv_hi, mdl_iv_lo};
        if (!mdl_cbc)
            res = run_rounds(din, mdl_dec);
        else if (!mdl_dec)
        begin
            res = run_rounds(din ^ mdl_chain, 1'b0);
            mdl_chain = res;
        end
        else
        begin
            res = run_rounds(din, 1'b1) ^ mdl_chain;
            mdl_chain = din;
        end
        return block_t'(res);
    endfunction

    function automatic logic [63:0] pick_word();
        case ($urandom_range(15))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, receiver stall, result checking and the watchdog.
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The receiver stalls at random, and solidly while a hold-off is in force.
    always @(posedge clk)
    begin
        out_stall <= hold_off || ($urandom_range(99) < sink_stall_pct);
    end

    // Every output beat is compared with the oldest block still owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (cipher_out_q.size() == 0)
            begin
                $error("output beat with nothing owed: out_high %h out_low %h",
                       out_high, out_low);
                error_count++;
            end
            else
            begin
                check_want = cipher_out_q.pop_front();
                if (out_high !== check_want.hi)
                begin
                    $error("out_high: expected %h, actual %h", check_want.hi, out_high);
                    error_count++;
                end
                if (out_low !== check_want.lo)
                begin
                    $error("out_low: expected %h, actual %h", check_want.lo, out_low);
                    error_count++;
                end
                checked_count++;
            end
        end
    end

    // A run that goes quiet on every channel for too long is treated as hung.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d blocks still owed",
                     quiet_cycles, cipher_out_q.size());
            $display("[sm4_block_cipher_ecb_cbc] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Channel drivers.
    // ------------------------------------------------------------------

    // Writes one register; the write beat completes when valid meets ready.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_count++;
        case (idx)
            sm4bc_pkg::REG_KEY_HIGH:
            begin
                mdl_key_hi   = val;
                mdl_rk_valid = 1'b0;
            end
            sm4bc_pkg::REG_KEY_LOW:
            begin
                mdl_key_lo   = val;
                mdl_rk_valid = 1'b0;
            end
            sm4bc_pkg::REG_IV_HIGH:    mdl_iv_hi = val;
            sm4bc_pkg::REG_IV_LOW:     mdl_iv_lo = val;
            sm4bc_pkg::REG_CHAIN_MODE: mdl_cbc   = val[0];
            sm4bc_pkg::REG_DECRYPT:    mdl_dec   = val[0];
            default:        ;
        endcase
        @(posedge clk);
    endtask

    // Offers one block and holds it until the block takes it. Valid stays high into
    // the next call unless a random gap is taken, so back-to-back beats never see
    // valid dropped and raised in the same step.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic fb);
        in_valid    <= 1'b1;
        data_high   <= hi;
        data_low    <= lo;
        first_block <= fb;
        do @(posedge clk); while (in_stall);
        cipher_out_q.push_back(sm4_process_block(hi, lo, fb));
        sent_count++;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    endtask

    // Drops valid and waits until every owed block has come out, so that the
    // registers may be written safely.
    task automatic settle();
        in_valid <= 1'b0;
        while (cipher_out_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Picks a fresh setting, writing a random subset of the registers. Mode and
    // direction get full 64-bit values to check that only bit zero is kept.
    task automatic randomize_config();
        if ($urandom_range(3) == 0)
            write_reg(sm4bc_pkg::REG_KEY_HIGH, pick_word());
        if ($urandom_range(3) == 0)
            write_reg(sm4bc_pkg::REG_KEY_LOW, pick_word());
        if ($urandom_range(1) == 0)
            write_reg(sm4bc_pkg::REG_IV_HIGH, pick_word());
        if ($urandom_range(1) == 0)
            write_reg(sm4bc_pkg::REG_IV_LOW, pick_word());
        if ($urandom_range(3) != 0)
            write_reg(sm4bc_pkg::REG_CHAIN_MODE, {$urandom, $urandom});
        if ($urandom_range(3) != 0)
            write_reg(sm4bc_pkg::REG_DECRYPT, {$urandom, $urandom});
        if ($urandom_range(7) == 0)
            write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, pick_word());
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Straight out of reset: zero key, ECB encrypt, keys never expanded yet.
    task automatic test_power_on_defaults();
        send_block(64'h0, 64'h0, 1'b1);
        settle();
    endtask

    // The published test vector, encrypted and then decrypted back.
    task automatic test_known_vector();
        write_reg(sm4bc_pkg::REG_KEY_HIGH, 64'h0123456789abcdef);
        write_reg(sm4bc_pkg::REG_KEY_LOW,  64'hfedcba9876543210);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
        settle();
        write_reg(sm4bc_pkg::REG_DECRYPT, 64'h1);
        send_block(64'h681edf34d206965e, 64'h86b3e94f536e4246, 1'b0);
        settle();
    endtask

    // Data extremes in ECB, both directions.
    task automatic test_ecb_extremes();
        write_reg(sm4bc_pkg::REG_DECRYPT, 64'h0);
        send_block(64'h0, 64'h0, 1'b0);
        send_block('1, '1, 1'b0);
        send_block(64'h8000000000000000, 64'h0000000000000001, 1'b0);
        send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0);
        settle();
        write_reg(sm4bc_pkg::REG_DECRYPT, 64'h1);
        send_block('1, 64'h0, 1'b0);
        send_block(64'h0, '1, 1'b0);
        settle();
    endtask

    // CBC chaining in both directions, a first block in ECB, an IV rewrite in the
    // middle of a message and mode changes in the middle of a message.
    task automatic test_cbc_chaining();
        write_reg(sm4bc_pkg::REG_IV_HIGH, 64'h0f1e2d3c4b5a6978);
        write_reg(sm4bc_pkg::REG_IV_LOW,  64'h8796a5b4c3d2e1f0);
        write_reg(sm4bc_pkg::REG_CHAIN_MODE, 64'h1);
        write_reg(sm4bc_pkg::REG_DECRYPT, 64'h0);
        send_block(64'h1111111111111111, 64'h2222222222222222, 1'b1);
        send_block(64'h3333333333333333, 64'h4444444444444444, 1'b0);
        send_block(64'h1111111111111111, 64'h2222222222222222, 1'b0);
        settle();
        write_reg(sm4bc_pkg::REG_DECRYPT, 64'h1);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        settle();
        // A new IV only counts from the next block flagged first.
        write_reg(sm4bc_pkg::REG_IV_HIGH, '1);
        write_reg(sm4bc_pkg::REG_IV_LOW,  '1);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        settle();
        // Switching to ECB leaves the chain alone; switching back picks it up as is.
        write_reg(sm4bc_pkg::REG_CHAIN_MODE, 64'h0);
        write_reg(sm4bc_pkg::REG_DECRYPT, 64'h0);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        settle();
        write_reg(sm4bc_pkg::REG_CHAIN_MODE, 64'h1);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        settle();
        // A first block in ECB still reloads the chain from the IV.
        write_reg(sm4bc_pkg::REG_IV_HIGH, 64'h0);
        write_reg(sm4bc_pkg::REG_CHAIN_MODE, 64'h0);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        settle();
        write_reg(sm4bc_pkg::REG_CHAIN_MODE, 64'h1);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        settle();
    endtask

    // All-ones key and IV, writes to unmapped indexes, over-wide mode and direction
    // values, and a key rewrite between two blocks of one message.
    task automatic test_config_corners();
        write_reg(sm4bc_pkg::REG_KEY_HIGH, '1);
        write_reg(sm4bc_pkg::REG_KEY_LOW,  '1);
        write_reg(sm4bc_pkg::REG_IV_HIGH,  '1);
        write_reg(sm4bc_pkg::REG_IV_LOW,   '1);
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, 64'h0123456789abcdef);
        write_reg(sm4bc_pkg::REG_CHAIN_MODE, 64'hfffffffffffffffe);
        write_reg(sm4bc_pkg::REG_DECRYPT,    64'hffffffff00000001);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        settle();
        write_reg(sm4bc_pkg::REG_CHAIN_MODE, 64'h8000000000000001);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        settle();
        write_reg(sm4bc_pkg::REG_KEY_LOW, 64'h0);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        settle();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // blocks, so the output register and the round unit both fill and the input
    // channel has to stall.
    task automatic test_input_backpressure();
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        write_reg(sm4bc_pkg::REG_CHAIN_MODE, 64'h1);
        write_reg(sm4bc_pkg::REG_DECRYPT, 64'h0);
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        for (int k = 0; k < 12; k++)
            send_block({$urandom, $urandom}, {$urandom, $urandom}, k == 0);
        settle();
    endtask

    // One random phase: mostly well-formed messages (first block flagged, the rest
    // not), with some stray first flags, and a new setting every forty-odd blocks.
    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n_blocks);
        int   done_blocks;
        int   since_cfg;
        int   msg_len;
        logic fb;
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        done_blocks     = 0;
        since_cfg       = 0;
        settle();
        randomize_config();
        while (done_blocks < n_blocks)
        begin
            if (since_cfg >= 40)
            begin
                settle();
                randomize_config();
                since_cfg = 0;
            end
            msg_len = $urandom_range(1, 6);
            for (int k = 0; k < msg_len; k++)
            begin
                if ($urandom_range(9) == 0)
                    fb = 1'($urandom_range(1));
                else
                    fb = (k == 0);
                send_block(pick_word(), pick_word(), fb);
            end
            done_blocks += msg_len;
            since_cfg   += msg_len;
        end
        settle();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 355);
        run_random_phase(47, 0, 355);
        run_random_phase(0, 47, 355);
        run_random_phase(7, 7, 355);
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        data_high       = '0;
        data_low        = '0;
        first_block     = 1'b0;
        out_stall       = 1'b0;
        hold_off        = 1'b0;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        error_count     = 0;
        sent_count      = 0;
        checked_count   = 0;
        cfg_count       = 0;
        quiet_cycles    = 0;

        // Mirror of the reset state: all registers zero, keys not yet expanded.
        mdl_key_hi   = '0;
        mdl_key_lo   = '0;
        mdl_iv_hi    = '0;
        mdl_iv_lo    = '0;
        mdl_cbc      = 1'b0;
        mdl_dec      = 1'b0;
        mdl_rk_valid = 1'b0;
        mdl_chain    = '0;
        for (int i = 0; i < 32; i++)
            mdl_rk[i] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_power_on_defaults();
        test_known_vector();
        test_ecb_extremes();
        test_cbc_chaining();
        test_config_corners();
        test_input_backpressure();
        test_random_traffic();

        // Everything has been sent; let the last blocks drain, then give the block
        // a while longer to show any stray output beat.
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (cipher_out_q.size() != 0)
        begin
            $error("%0d result blocks never arrived", cipher_out_q.size());
            error_count++;
        end

        $display("Sent %0d blocks and checked %0d results over %0d register writes,",
                 sent_count, checked_count, cfg_count);
        $display("covering ECB and CBC, both directions, key and IV rewrites and backpressure.");
        if (error_count == 0)
            $display("[sm4_block_cipher_ecb_cbc] OK");
        else
            $display("[sm4_block_cipher_ecb_cbc] ERROR");
        $finish;
    end

endmodule

/* sm4_block_cipher_ecb_cbc.f */
rtl/sm4bc_pkg.sv
rtl/sm4bc_round_unit.sv
rtl/sm4bc_key_mem.sv
rtl/sm4_block_cipher_ecb_cbc.sv
bench/tb.sv
